// File: hw/rtl/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and constant tables of the tone step sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int STEP_DEPTH = 256;
	localparam int STEP_AW    = $clog2(STEP_DEPTH);
	localparam int NUM_CHANS  = 3;
	localparam int CHAN_AW    = 2;
	localparam int VOL_MAX    = 15;
	localparam int VOL_FULL   = 64;

	localparam logic [15:0] MIN_PERIOD_RST   = 16'd124;
	localparam logic [15:0] NOISE_PERIOD_RST = 16'd320;

	// request opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_HOLD  = 2'd3;

	localparam logic [1:0] NOISE_VOICE = 2'd3;
	localparam logic [1:0] EFFECTS_CH  = 2'd2;
	localparam logic [1:0] BAD_CH      = 2'd3;

	localparam logic CFG_MIN_PERIOD   = 1'b0;
	localparam logic CFG_NOISE_PERIOD = 1'b1;

	typedef struct packed {
		logic [7:0]  dur;
		logic [15:0] per;
		logic [3:0]  vol;
		logic        noise;
	} step_t;

	typedef struct packed {
		logic [STEP_AW-1:0] pos;
		logic [STEP_AW-1:0] start;
		logic [7:0]         cd;
		logic               active;
		logic               looping;
	} chan_t;

	typedef struct packed {
		logic [1:0]  voice;
		logic [15:0] period;
		logic [6:0]  volume;
		logic        sound_on;
		logic        last;
	} res_t;

	typedef logic [STEP_AW-1:0] addr_lut_t [256];
	typedef logic [6:0] vol_lut_t [16];

	// request address folded onto the step memory
	function automatic addr_lut_t make_addr_lut();
		addr_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = STEP_AW'(i % STEP_DEPTH);
		end
		return lut;
	endfunction

	// volume 0..15 scaled to 0..64
	function automatic vol_lut_t make_vol_lut();
		vol_lut_t lut;
		for (int i = 0; i < 16; i++) begin
			lut[i] = 7'((i * VOL_FULL) / VOL_MAX);
		end
		return lut;
	endfunction

	localparam addr_lut_t ADDR_LUT = make_addr_lut();
	localparam vol_lut_t  VOL_LUT  = make_vol_lut();

endpackage
`default_nettype wire

// File: hw/rtl/tone_step_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_step_sequencer
// Three-channel note sequencer: step memory, per-channel state, voice writes.
// ----------------------------------------------------------------------------
// Requests enter on item_valid/item_stall: op selects tick, step write,
// channel start or sample hold. Voice writes leave on wr_valid/wr_stall, one
// per write, with last set on the final write of a request. Registers
// min_period (index 0) and noise_period (index 1) are written on the cfg
// port, which is always ready.
// One request is in work at a time. A tick visits the channels in turn,
// reading each channel's entry in the channel memory and, when a step is
// due, the step memory; a noise or effects step adds a second write, a loop
// restart a second step read, and the end of the sample hold a silencing
// write first. The last write of a request is held back one slot until its
// end is known, then moves on to the output register.
// Reset idles all channels, clears the sample hold and loads the register
// defaults; step memory content is undefined until written. A stalled
// receiver holds the output register; the sequencer then waits as soon as
// its held-back write cannot move on.
// ----------------------------------------------------------------------------
module tone_step_sequencer import tss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  op,
	input  wire logic [1:0]  channel,
	input  wire logic [7:0]  address,
	input  wire logic        has_sequence,
	input  wire logic        loop_enable,
	input  wire logic [7:0]  step_duration,
	input  wire logic [15:0] step_period,
	input  wire logic [3:0]  step_volume,
	input  wire logic        step_noise,
	input  wire logic [15:0] sample_frames,
	output logic             wr_valid,
	input  wire logic        wr_stall,
	output logic [1:0]       voice,
	output logic [15:0]      period,
	output logic [6:0]       volume,
	output logic             sound_on,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SIL   = 3'd1;
	localparam logic [2:0] S_CRD   = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_SRD   = 3'd4;
	localparam logic [2:0] S_SCHK  = 3'd5;
	localparam logic [2:0] S_NOTE2 = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [2:0]           state_q, state_d;
	logic [CHAN_AW-1:0]   ch_q, nchan_q;
	logic                 tick_q;
	logic [1:0]           sil_voice_q, voice2_q;
	logic                 restarted_q;
	chan_t                wk_q;
	logic [15:0]          hold_q;
	logic [15:0]          min_period_q, noise_period_q;
	logic [NUM_CHANS-1:0] chan_vld_q;
	res_t                 pend_q, wr_q;
	logic                 pend_v_q, wr_valid_q;

	logic                 item_acc;
	logic                 can_push, gen_ok, gen_v, push, next_ch;
	res_t                 gen;
	logic                 chan_we;
	logic [CHAN_AW-1:0]   chan_waddr;
	chan_t                chan_wdata, chan_rd;
	logic [$bits(chan_t)-1:0] chan_rdata;
	logic                 step_we;
	step_t                step_wdata, step_rd;
	logic [$bits(step_t)-1:0] step_rdata;
	logic [7:0]           cd_dec;
	logic [15:0]          per_in, note_per;
	logic [STEP_AW-1:0]   pos_next;

	// memories
	tss_ram #(
		.WIDTH ($bits(step_t)),
		.DEPTH (STEP_DEPTH)
	) u_step_ram (
		.clk   (clk),
		.we    (step_we),
		.waddr (ADDR_LUT[address]),
		.wdata (step_wdata),
		.raddr (wk_q.pos),
		.rdata (step_rdata)
	);

	tss_ram #(
		.WIDTH ($bits(chan_t)),
		.DEPTH (NUM_CHANS)
	) u_chan_ram (
		.clk   (clk),
		.we    (chan_we),
		.waddr (chan_waddr),
		.wdata (chan_wdata),
		.raddr (ch_q),
		.rdata (chan_rdata)
	);

	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign step_we    = item_acc && (op == OP_WRITE);
	assign step_wdata = '{dur: step_duration, per: step_period, vol: step_volume,
		noise: step_noise};

	// entries never written since reset read as an idle channel
	assign chan_rd = chan_vld_q[ch_q] ? chan_t'(chan_rdata) : '0;
	assign step_rd = step_t'(step_rdata);

	assign cd_dec   = chan_rd.cd - 8'd1;
	assign per_in   = step_rd.noise ? noise_period_q : step_rd.per;
	assign note_per = (per_in < min_period_q) ? min_period_q : per_in;
	assign pos_next = (wk_q.pos == STEP_AW'(STEP_DEPTH - 1)) ? '0 : wk_q.pos + 1'b1;

	// the held-back write moves to the output register when a newer one comes or the request ends
	assign can_push = !wr_valid_q || !wr_stall;
	assign gen_ok   = !pend_v_q || can_push;
	assign push     = pend_v_q && can_push && ((gen_v && gen_ok) || (state_q == S_FLUSH));

	always_comb begin
		state_d    = state_q;
		gen_v      = 1'b0;
		gen        = '0;
		chan_we    = 1'b0;
		chan_waddr = ch_q;
		chan_wdata = wk_q;
		next_ch    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					case (op)
						OP_TICK: begin
							state_d = (hold_q == 16'd1) ? S_SIL : S_CRD;
						end
						OP_START: begin
							if (channel != BAD_CH) begin
								chan_we    = 1'b1;
								chan_waddr = channel;
								chan_wdata = '{pos: ADDR_LUT[address], start: ADDR_LUT[address],
									cd: 8'd1, active: has_sequence, looping: loop_enable};
								if (!has_sequence) begin
									state_d = S_SIL;
								end
							end
						end
						OP_HOLD: begin
							chan_we    = 1'b1;
							chan_waddr = EFFECTS_CH;
							chan_wdata = '{pos: '0, start: '0, cd: 8'd1, active: 1'b0,
								looping: 1'b0};
							state_d    = S_SIL;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SIL: begin
				gen_v = 1'b1;
				gen   = '{voice: sil_voice_q, period: '0, volume: '0, sound_on: 1'b0,
					last: 1'b0};
				if (gen_ok) begin
					state_d = tick_q ? S_CRD : S_FLUSH;
				end
			end
			S_CRD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!chan_rd.active) begin
					next_ch = 1'b1;
				end else if (cd_dec != 8'd0) begin
					chan_we       = 1'b1;
					chan_wdata    = chan_rd;
					chan_wdata.cd = cd_dec;
					next_ch       = 1'b1;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (step_rd.dur == 8'd0) begin
					if (wk_q.looping && !restarted_q) begin
						state_d = S_SRD;
					end else begin
						gen_v = 1'b1;
						gen   = '{voice: ch_q, period: '0, volume: '0, sound_on: 1'b0,
							last: 1'b0};
						if (gen_ok) begin
							chan_we           = 1'b1;
							chan_wdata.active = 1'b0;
							next_ch           = 1'b1;
						end
					end
				end else begin
					gen_v = 1'b1;
					gen   = '{voice: step_rd.noise ? NOISE_VOICE : ch_q, period: note_per,
						volume: VOL_LUT[step_rd.vol], sound_on: 1'b1, last: 1'b0};
					if (gen_ok) begin
						chan_we        = 1'b1;
						chan_wdata.pos = pos_next;
						chan_wdata.cd  = step_rd.dur;
						if (step_rd.noise || (ch_q == EFFECTS_CH)) begin
							state_d = S_NOTE2;
						end else begin
							next_ch = 1'b1;
						end
					end
				end
			end
			S_NOTE2: begin
				gen_v = 1'b1;
				gen   = '{voice: voice2_q, period: '0, volume: '0, sound_on: 1'b0,
					last: 1'b0};
				if (gen_ok) begin
					next_ch = 1'b1;
				end
			end
			S_FLUSH: begin
				if (!pend_v_q || can_push) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (next_ch) begin
			state_d = (ch_q + 1'b1 == nchan_q) ? S_FLUSH : S_CRD;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ch_q           <= '0;
			nchan_q        <= '0;
			tick_q         <= 1'b0;
			hold_q         <= '0;
			chan_vld_q     <= '0;
			pend_v_q       <= 1'b0;
			wr_valid_q     <= 1'b0;
			min_period_q   <= MIN_PERIOD_RST;
			noise_period_q <= NOISE_PERIOD_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_PERIOD:   min_period_q   <= cfg_data;
					CFG_NOISE_PERIOD: noise_period_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (chan_we) begin
				chan_vld_q[chan_waddr] <= 1'b1;
			end
			if (item_acc) begin
				ch_q   <= '0;
				tick_q <= (op == OP_TICK);
				if (op == OP_TICK) begin
					nchan_q <= (hold_q != 16'd0) ? CHAN_AW'(NUM_CHANS - 1) : CHAN_AW'(NUM_CHANS);
					if (hold_q != 16'd0) begin
						hold_q <= hold_q - 16'd1;
					end
				end else if (op == OP_START && channel == EFFECTS_CH) begin
					hold_q <= '0;
				end else if (op == OP_HOLD) begin
					hold_q <= sample_frames;
				end
			end
			if (next_ch) begin
				ch_q <= ch_q + 1'b1;
			end
			if (gen_v && gen_ok) begin
				pend_v_q <= 1'b1;
			end else if (push) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				wr_valid_q <= 1'b1;
			end else if (!wr_stall) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			// a tick only silences the effects voice when its sample hold ends
			sil_voice_q <= (op == OP_START) ? channel : EFFECTS_CH;
		end
		if (state_q == S_CHK) begin
			wk_q        <= '{pos: chan_rd.pos, start: chan_rd.start, cd: cd_dec,
				active: chan_rd.active, looping: chan_rd.looping};
			restarted_q <= 1'b0;
		end
		if (state_q == S_SCHK && step_rd.dur == 8'd0 && wk_q.looping && !restarted_q) begin
			wk_q.pos    <= wk_q.start;
			restarted_q <= 1'b1;
		end
		if (state_q == S_SCHK) begin
			voice2_q <= step_rd.noise ? ch_q : NOISE_VOICE;
		end
		if (gen_v && gen_ok) begin
			pend_q <= gen;
		end
		if (push) begin
			wr_q <= '{voice: pend_q.voice, period: pend_q.period, volume: pend_q.volume,
				sound_on: pend_q.sound_on, last: (state_q == S_FLUSH)};
		end
	end

	assign wr_valid = wr_valid_q;
	assign voice    = wr_q.voice;
	assign period   = wr_q.period;
	assign volume   = wr_q.volume;
	assign sound_on = wr_q.sound_on;
	assign last     = wr_q.last;

	// a new request never finds a write of the previous one held back
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |-> !pend_v_q)
		else $error("request accepted with a held-back write");

	// the output register only loads when it is free or being taken
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!wr_valid_q || !wr_stall))
		else $error("output register overwritten");

	a_chan_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_we |-> (chan_waddr != BAD_CH))
		else $error("channel memory write out of range");

	// leaving flush hands the final write over
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && state_d == S_IDLE) |=> !pend_v_q)
		else $error("final write lost at end of request");

	a_chan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK || state_q == S_SCHK || state_q == S_NOTE2) |->
			(ch_q != BAD_CH && ch_q < nchan_q))
		else $error("channel index out of range");

endmodule
`default_nettype wire

// File: hw/rtl/tss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: dv/tone_step_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_step_sequencer_checker
// Watches the request, voice write and register ports of the sequencer, keeps
// its own copy of the step memory and channel state, works out the voice
// writes that each request causes and compares them in order with the writes
// that leave the block.
// ----------------------------------------------------------------------------
module tone_step_sequencer_checker import tss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_stall,
	input  wire logic [1:0]  op,
	input  wire logic [1:0]  channel,
	input  wire logic [7:0]  address,
	input  wire logic        has_sequence,
	input  wire logic        loop_enable,
	input  wire logic [7:0]  step_duration,
	input  wire logic [15:0] step_period,
	input  wire logic [3:0]  step_volume,
	input  wire logic        step_noise,
	input  wire logic [15:0] sample_frames,
	input  wire logic        wr_valid,
	input  wire logic        wr_stall,
	input  wire logic [1:0]  voice,
	input  wire logic [15:0] period,
	input  wire logic [6:0]  volume,
	input  wire logic        sound_on,
	input  wire logic        last,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               errors = 0,
	output int               pending = 0
);

	step_t              step_mem [STEP_DEPTH];
	logic [STEP_AW-1:0] seq_pos [NUM_CHANS];
	logic [STEP_AW-1:0] seq_first [NUM_CHANS];
	logic [7:0]         seq_count [NUM_CHANS];
	logic               seq_on [NUM_CHANS];
	logic               seq_loop [NUM_CHANS];
	logic [15:0]        hold_left;
	logic [15:0]        floor_period;
	logic [15:0]        drum_period;

	res_t voice_writes_due [$];
	res_t request_writes [$];

	task automatic report(string msg);
		errors++;
		$display("ERROR %0t ns: %s", $time, msg);
	endtask

	function automatic void queue_write(logic [1:0] v, logic [15:0] p, logic [6:0] vol,
			logic on);
		res_t w;
		w.voice    = v;
		w.period   = p;
		w.volume   = vol;
		w.sound_on = on;
		w.last     = 1'b0;
		request_writes.push_back(w);
	endfunction

	function automatic void mute(logic [1:0] v);
		queue_write(v, 16'd0, 7'd0, 1'b0);
	endfunction

	function automatic void play(logic [1:0] v, logic [15:0] p, logic [3:0] vol);
		logic [15:0] clamped;
		clamped = (p < floor_period) ? floor_period : p;
		queue_write(v, clamped, 7'(int'(vol) * VOL_FULL / VOL_MAX), 1'b1);
	endfunction

	function automatic void advance_channel(int c);
		step_t      s;
		logic [1:0] own;
		own = 2'(c);
		if (!seq_on[c])
			return;
		seq_count[c] = seq_count[c] - 8'd1;
		if (seq_count[c] != 8'd0)
			return;
		s = step_mem[seq_pos[c]];
		// a looping channel gets one restart; an empty loop stops it
		if (s.dur == 8'd0 && seq_loop[c]) begin
			seq_pos[c] = seq_first[c];
			s = step_mem[seq_pos[c]];
		end
		if (s.dur == 8'd0) begin
			seq_on[c] = 1'b0;
			mute(own);
			return;
		end
		seq_count[c] = s.dur;
		if (s.noise) begin
			play(NOISE_VOICE, drum_period, s.vol);
			mute(own);
		end else begin
			play(own, s.per, s.vol);
			if (own == EFFECTS_CH)
				mute(NOISE_VOICE);
		end
		seq_pos[c] = seq_pos[c] + 1'b1;
	endfunction

	function automatic void restart_channel(int c, logic [STEP_AW-1:0] a, logic on,
			logic lp);
		seq_pos[c]   = a;
		seq_first[c] = a;
		seq_count[c] = 8'd1;
		seq_on[c]    = on;
		seq_loop[c]  = lp;
	endfunction

	function automatic void predict_voice_writes();
		request_writes.delete();
		case (op)
			OP_TICK: begin
				if (hold_left != 16'd0) begin
					hold_left = hold_left - 16'd1;
					if (hold_left == 16'd0)
						mute(EFFECTS_CH);
					advance_channel(0);
					advance_channel(1);
				end else begin
					for (int c = 0; c < NUM_CHANS; c++)
						advance_channel(c);
				end
			end
			OP_WRITE: begin
				step_mem[ADDR_LUT[address]] = '{step_duration, step_period, step_volume,
					step_noise};
			end
			OP_START: begin
				if (channel != BAD_CH) begin
					restart_channel(int'(channel), ADDR_LUT[address], has_sequence,
						loop_enable);
					if (channel == EFFECTS_CH)
						hold_left = 16'd0;
					if (!has_sequence)
						mute(channel);
				end
			end
			OP_HOLD: begin
				restart_channel(int'(EFFECTS_CH), '0, 1'b0, 1'b0);
				mute(EFFECTS_CH);
				hold_left = sample_frames;
			end
		endcase
		if (request_writes.size() > 0)
			request_writes[$].last = 1'b1;
		foreach (request_writes[i])
			voice_writes_due.push_back(request_writes[i]);
	endfunction

	function automatic string show(res_t w);
		return $sformatf("voice %0d period %0d volume %0d on %0b last %0b",
			w.voice, w.period, w.volume, w.sound_on, w.last);
	endfunction

	task automatic check_voice_write();
		res_t got;
		res_t want;
		got = {voice, period, volume, sound_on, last};
		if (voice_writes_due.size() == 0) begin
			report($sformatf("voice write with none due: %s", show(got)));
			return;
		end
		want = voice_writes_due.pop_front();
		if (got.voice !== want.voice || got.period !== want.period ||
				got.volume !== want.volume || got.sound_on !== want.sound_on ||
				got.last !== want.last)
			report($sformatf("voice write got %s, want %s", show(got), show(want)));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANS; c++)
				restart_channel(c, '0, 1'b0, 1'b0);
			seq_count = '{default: 8'd0};
			hold_left = 16'd0;
			floor_period = MIN_PERIOD_RST;
			drum_period = NOISE_PERIOD_RST;
			voice_writes_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_PERIOD:   floor_period = cfg_data;
					CFG_NOISE_PERIOD: drum_period = cfg_data;
				endcase
			end
			if (item_valid && !item_stall)
				predict_voice_writes();
			if (wr_valid && !wr_stall)
				check_voice_write();
			pending <= voice_writes_due.size();
		end
	end

endmodule

// File: dv/tone_step_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_step_sequencer_tb
// Drives the sequencer with step writes, channel starts, sample holds and
// ticks: a directed opening, then random phases of well-formed sequences and
// noise under several period settings, with bursty requests and a stalling
// voice write receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tone_step_sequencer_tb;
	import tss_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 25;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  chan;
		logic [7:0]  addr;
		logic        has;
		logic        loop_on;
		logic [7:0]  dur;
		logic [15:0] per;
		logic [3:0]  vol;
		logic        noise;
		logic [15:0] frames;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  op = OP_TICK;
	logic [1:0]  channel = 2'd0;
	logic [7:0]  address = 8'd0;
	logic        has_sequence = 1'b0;
	logic        loop_enable = 1'b0;
	logic [7:0]  step_duration = 8'd0;
	logic [15:0] step_period = 16'd0;
	logic [3:0]  step_volume = 4'd0;
	logic        step_noise = 1'b0;
	logic [15:0] sample_frames = 16'd0;
	logic        wr_valid;
	logic        wr_stall = 1'b0;
	logic [1:0]  voice;
	logic [15:0] period;
	logic [6:0]  volume;
	logic        sound_on;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_MIN_PERIOD;
	logic [15:0] cfg_data = 16'd0;

	int write_errors;
	int writes_pending;
	int items_sent = 0;
	int burst_left = 4;
	int quiet_cycles = 0;
	int stall_cycle = 0;
	int stall_mode = 0;
	bit written [256];

	tone_step_sequencer dut (.*);

	tone_step_sequencer_checker checker_i (
		.errors(write_errors),
		.pending(writes_pending),
		.*
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stall pattern is re-picked at random from four modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_stall <= 1'b0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			if (stall_cycle % 128 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: wr_stall <= 1'b0;
				1: wr_stall <= ($urandom_range(0, 3) == 0);
				2: wr_stall <= ($urandom_range(0, 3) != 0);
				default: wr_stall <= (stall_cycle % 8 < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (wr_valid && !wr_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int next_burst();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
	endfunction

	task automatic send(request_t r);
		item_valid    <= 1'b1;
		op            <= r.op;
		channel       <= r.chan;
		address       <= r.addr;
		has_sequence  <= r.has;
		loop_enable   <= r.loop_on;
		step_duration <= r.dur;
		step_period   <= r.per;
		step_volume   <= r.vol;
		step_noise    <= r.noise;
		sample_frames <= r.frames;
		do @(posedge clk); while (item_stall);
		if (!(r.op == OP_START && r.chan == BAD_CH))
			items_sent++;
		burst_left--;
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = next_burst();
		end
	endtask

	// unused fields carry random bits
	function automatic request_t scrambled(logic [1:0] code);
		request_t r;
		r.op      = code;
		r.chan    = 2'($urandom);
		r.addr    = 8'($urandom);
		r.has     = 1'($urandom);
		r.loop_on = 1'($urandom);
		r.dur     = 8'($urandom);
		r.per     = 16'($urandom);
		r.vol     = 4'($urandom);
		r.noise   = 1'($urandom);
		r.frames  = 16'($urandom);
		return r;
	endfunction

	task automatic put_step(logic [7:0] a, logic [7:0] d, logic [15:0] p, logic [3:0] v,
			logic nz);
		request_t r;
		r = scrambled(OP_WRITE);
		r.addr  = a;
		r.dur   = d;
		r.per   = p;
		r.vol   = v;
		r.noise = nz;
		send(r);
		written[a] = 1'b1;
	endtask

	task automatic start_seq(logic [1:0] ch, logic [7:0] a, logic on, logic lp);
		request_t r;
		r = scrambled(OP_START);
		r.chan    = ch;
		r.addr    = a;
		r.has     = on;
		r.loop_on = lp;
		send(r);
	endtask

	task automatic tick();
		send(scrambled(OP_TICK));
	endtask

	task automatic hold(logic [15:0] frames);
		request_t r;
		r = scrambled(OP_HOLD);
		r.frames = frames;
		send(r);
	endtask

	function automatic logic [7:0] step_len();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 17)
			return 8'($urandom_range(1, 3));
		else if (pick < 19)
			return 8'($urandom_range(4, 8));
		return 8'd255;
	endfunction

	function automatic logic [15:0] step_tone();
		int pick;
		pick = $urandom_range(0, 3);
		if (pick < 2)
			return 16'($urandom);
		else if (pick == 2)
			return 16'($urandom_range(0, 300));
		return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
	endfunction

	function automatic logic [15:0] hold_frames();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return 16'($urandom_range(1, 6));
		else if (pick == 7)
			return 16'd0;
		else if (pick == 8)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [1:0] pick_channel();
		return ($urandom_range(0, 15) == 0) ? BAD_CH : 2'($urandom_range(0, 2));
	endfunction

	function automatic logic [7:0] pick_written();
		logic [7:0] a;
		do a = 8'($urandom); while (!written[a]);
		return a;
	endfunction

	// terminator first, then steps backwards, so every playable step is followed
	// by an entry that has been written
	task automatic write_sequence(logic [7:0] base, int n);
		put_step(base + 8'(n), 8'd0, 16'($urandom), 4'($urandom), 1'($urandom));
		for (int k = n - 1; k >= 0; k--)
			put_step(base + 8'(k), step_len(), step_tone(), 4'($urandom),
				$urandom_range(0, 3) == 0);
	endtask

	task automatic scribble();
		logic [7:0] a;
		logic [7:0] d;
		a = 8'($urandom);
		d = 8'd0;
		if (written[a + 8'd1])
			d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		put_step(a, d, step_tone(), 4'($urandom), 1'($urandom));
	endtask

	task automatic random_request();
		int pick;
		logic [7:0] base;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			tick();
		end else if (pick < 65) begin
			base = 8'($urandom);
			write_sequence(base, $urandom_range(1, 4));
			if ($urandom_range(0, 9) < 8)
				start_seq(pick_channel(), base, 1'b1, 1'($urandom));
		end else if (pick < 80) begin
			start_seq(pick_channel(), pick_written(), $urandom_range(0, 7) != 0,
				1'($urandom));
		end else if (pick < 90) begin
			hold(hold_frames());
		end else begin
			scribble();
		end
	endtask

	task automatic set_periods(logic [15:0] floor_p, logic [15:0] drum_p);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MIN_PERIOD;
		cfg_data  <= floor_p;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_NOISE_PERIOD;
		cfg_data  <= drum_p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// idle the request side and let every due write arrive
	task automatic drain();
		if (item_valid)
			item_valid <= 1'b0;
		@(posedge clk);
		while (writes_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int target;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening at the reset periods
		put_step(8'd3, 8'd0, 16'h5A5A, 4'd9, 1'b1);
		put_step(8'd2, 8'd1, 16'h0050, 4'd7, 1'b0);
		put_step(8'd1, 8'd2, 16'hFFFF, 4'd0, 1'b1);
		put_step(8'd0, 8'd1, 16'h0000, 4'd15, 1'b0);
		put_step(8'd255, 8'd1, 16'h1234, 4'd8, 1'b1);
		put_step(8'd254, 8'd1, 16'd123, 4'd1, 1'b0);
		put_step(8'd200, 8'd0, 16'hFFFF, 4'd15, 1'b0);
		start_seq(2'd1, 8'd200, 1'b1, 1'b1);   // empty loop
		start_seq(2'd0, 8'd254, 1'b1, 1'b1);   // wraps past the top entry
		start_seq(EFFECTS_CH, 8'd0, 1'b1, 1'b0);
		start_seq(BAD_CH, 8'd9, 1'b1, 1'b1);
		repeat (3) tick();
		hold(16'd2);
		repeat (2) tick();
		hold(16'hFFFF);
		start_seq(EFFECTS_CH, 8'd1, 1'b1, 1'b1);   // clears the hold
		tick();
		start_seq(2'd0, 8'd0, 1'b0, 1'b0);         // stop request
		hold(16'd0);
		repeat (2) tick();

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: set_periods(16'd0, 16'd0);
				1: set_periods(16'hFFFF, 16'hFFFF);
				2: set_periods(16'($urandom), 16'($urandom));
				default: set_periods(16'd300, 16'd1);
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_request();
		end

		drain();
		if (write_errors == 0 && writes_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/tss_pkg.sv
hw/rtl/tss_ram.sv
hw/rtl/tone_step_sequencer.sv
dv/tone_step_sequencer_checker.sv
dv/tone_step_sequencer_tb.sv
